### hw/rtl/arbf_pkg.sv
// ----------------------------------------------------------------------------
// arbf_pkg
// Shared constants, types and helpers for the audio ring block feeder.
// ----------------------------------------------------------------------------
package arbf_pkg;

  localparam int unsigned RING_PAIRS  = 2048;
  localparam int unsigned BLOCK_PAIRS = 256;
  localparam int unsigned MAX_BLOCKS  = 32;

  localparam int unsigned SLOT_W  = $clog2(RING_PAIRS);
  localparam int unsigned FILL_W  = $clog2(RING_PAIRS + 1);
  localparam int unsigned BLK_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned NB_W    = BLK_W + 1;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IDATA_W = 8;
  localparam int unsigned ODATA_W = 168;

  localparam logic [FILL_W-1:0] RING_FULL  = FILL_W'(RING_PAIRS);
  localparam logic [FILL_W-1:0] BLOCK_FILL = FILL_W'(BLOCK_PAIRS);
  localparam logic [SLOT_W-1:0] BLOCK_STEP = SLOT_W'(BLOCK_PAIRS);

  typedef enum logic [KIND_W-1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_RING    = 2'd2,
    KIND_SILENCE = 2'd3
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted word
    logic push;       // apply a push and load its result
    logic serv_step;  // emit one descriptor
  } arbf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic stop_now;   // no descriptor due at service start
    logic stop_next;  // the descriptor being emitted is the final one
  } arbf_stat_t;

  // Decode the configured block count to a power of two
  function automatic logic [NB_W-1:0] block_count(input logic [NB_W-1:0] cfg);
    logic [NB_W-1:0] nb;
    if (cfg >= NB_W'(32)) begin
      nb = NB_W'(32);
    end else if (cfg >= NB_W'(16)) begin
      nb = NB_W'(16);
    end else begin
      nb = NB_W'(8);
    end
    return nb;
  endfunction

endpackage

### hw/rtl/arbf_ctrl.sv
// ----------------------------------------------------------------------------
// arbf_ctrl
// Sequencer for push and service words of the audio ring block feeder.
// ----------------------------------------------------------------------------
module arbf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_mode,
  output logic                in_tready,
  input  arbf_pkg::arbf_stat_t stat,
  output arbf_pkg::arbf_cmd_t  cmd
);
  import arbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_CHECK,
    S_SERV
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? S_CHECK : S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        state_nxt = stat.stop_now ? S_IDLE : S_SERV;
      end
      S_SERV: begin
        if (stat.out_free) begin
          cmd.serv_step = 1'b1;
          if (stat.stop_next) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/arbf_dpath.sv
// ----------------------------------------------------------------------------
// arbf_dpath
// Ring pointers, statistics counters and the result register.
// ----------------------------------------------------------------------------
module arbf_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [arbf_pkg::NB_W-1:0]        cfg_wr_data,
  input  logic                             in_frame_last,
  input  logic                             in_mode,
  input  logic [arbf_pkg::BLK_W-1:0]       in_play_blk,
  input  arbf_pkg::arbf_cmd_t              cmd,
  output arbf_pkg::arbf_stat_t             stat,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic                             out_tlast,
  output logic [arbf_pkg::KIND_W-1:0]      out_kind,
  output logic [arbf_pkg::ODATA_W-1:0]     out_data
);
  import arbf_pkg::*;

  logic [NB_W-1:0]   nblk_cfg_r;
  logic [SLOT_W-1:0] head_r, tail_r;
  logic [FILL_W-1:0] held_r, peak_r;
  logic              drop_r, flast_r;
  logic [BLK_W-1:0]  nbk_r, rb_r;
  logic [NB_W-1:0]   k_r;
  logic [CNT_W-1:0]  ovf_r, sil_r, bdone_r, frames_r;

  logic              out_valid_r, out_last_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [BLK_W-1:0]  out_blk_r;

  logic [NB_W-1:0]   nb;
  logic [BLK_W-1:0]  mask;
  logic [NB_W-1:0]   ahead_lim;
  logic [BLK_W-1:0]  ahead, nbk1, ahead1;
  logic              have_block;
  logic [FILL_W-1:0] held1;
  logic [CNT_W-1:0]  bdone1;

  logic              full, store, ovf_hit;
  logic [FILL_W-1:0] held_p;

  // Block ring geometry
  assign nb        = block_count(nblk_cfg_r);
  assign mask      = BLK_W'(nb - NB_W'(1));
  assign ahead_lim = nb - NB_W'(2);
  assign ahead     = (nbk_r - rb_r) & mask;
  assign have_block = (held_r >= BLOCK_FILL);

  // State after the descriptor now being emitted
  assign nbk1   = (nbk_r + BLK_W'(1)) & mask;
  assign ahead1 = (nbk1 - rb_r) & mask;
  assign held1  = have_block ? held_r - BLOCK_FILL : held_r;
  assign bdone1 = bdone_r + CNT_W'(1);

  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.stop_now  = ({1'b0, ahead} >= ahead_lim) ||
                          (!have_block && (bdone_r != '0));
  assign stat.stop_next = ((k_r + NB_W'(1)) == nb) ||
                          ({1'b0, ahead1} >= ahead_lim) ||
                          ((held1 < BLOCK_FILL) && (bdone1 != '0));

  // Push decisions
  assign full    = (held_r >= RING_FULL);
  assign store   = !drop_r && !full;
  assign ovf_hit = !drop_r && full;
  assign held_p  = held_r + FILL_W'(store);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nblk_cfg_r  <= NB_W'(8);
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      drop_r      <= 1'b0;
      nbk_r       <= '0;
      peak_r      <= '0;
      ovf_r       <= '0;
      sil_r       <= '0;
      bdone_r     <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        nblk_cfg_r <= cfg_wr_data;
      end
      if (cmd.load && in_mode) begin
        nbk_r <= nbk_r & mask;
      end
      if (cmd.push) begin
        if (store) begin
          tail_r <= tail_r + SLOT_W'(1);
        end
        held_r <= held_p;
        if (ovf_hit) begin
          ovf_r <= ovf_r + CNT_W'(1);
        end
        if (flast_r) begin
          frames_r <= frames_r + CNT_W'(1);
          if (held_p > peak_r) begin
            peak_r <= held_p;
          end
          drop_r <= 1'b0;
        end else if (ovf_hit) begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.serv_step) begin
        if (have_block) begin
          head_r <= head_r + BLOCK_STEP;
        end else begin
          sil_r <= sil_r + CNT_W'(1);
        end
        held_r  <= held1;
        nbk_r   <= nbk1;
        bdone_r <= bdone1;
      end
      if (cmd.push || cmd.serv_step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flast_r <= in_frame_last;
      rb_r    <= in_play_blk & mask;
      k_r     <= '0;
    end
    if (cmd.push) begin
      out_kind_r <= store ? KIND_STORED : KIND_DROPPED;
      out_slot_r <= store ? tail_r : '0;
      out_blk_r  <= '0;
      out_last_r <= 1'b1;
    end
    if (cmd.serv_step) begin
      out_kind_r <= have_block ? KIND_RING : KIND_SILENCE;
      out_slot_r <= have_block ? head_r : '0;
      out_blk_r  <= nbk_r;
      out_last_r <= stat.stop_next;
      k_r        <= k_r + NB_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_kind   = out_kind_r;
  // Counters and fill are live state: they only change when a new result loads
  assign out_data   = {frames_r, bdone_r, sil_r, ovf_r, peak_r, held_r,
                       out_blk_r, out_slot_r};

endmodule

### hw/rtl/audio_ring_block_feeder_unit.sv
// ----------------------------------------------------------------------------
// audio_ring_block_feeder_unit
// Sample-pair ring controller that feeds a ring of playback blocks.
// ----------------------------------------------------------------------------
// A push word (in_tuser low) books one stereo pair into the ring and yields one
// result word from the push state that follows acceptance; a full ring counts
// one overflow and drops the rest of that frame up to in_tlast. A service word
// (in_tuser high) carries the block the player reads and yields from none up to
// two fewer than the decoded block count of descriptor words, one per cycle
// while the output is not stalled, after a check state, each either a copy of
// BLOCK_PAIRS pairs from the ring head or a silence block; out_tlast marks the
// final word of a service and every push result. One word is worked on at a
// time: in_tready rises again once the final result is loaded into the output
// register, or once the check finds no descriptor due. A stalled output holds
// the sequencer. The pair payload lives in an external memory addressed by
// the ring slot in each result word. Write cfg_wr_data only while the unit is
// idle; 32 and above selects 32 blocks, 16 to 31 selects 16, below that 8.
// ----------------------------------------------------------------------------
module audio_ring_block_feeder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration: num_blocks
  input  logic                          cfg_wr_en,
  input  logic [arbf_pkg::NB_W-1:0]     cfg_wr_data,
  // Input words
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [arbf_pkg::IDATA_W-1:0]  in_tdata,  // [4:0] player block, rest zero
  input  logic                          in_tuser,  // [0] mode
  input  logic                          in_tlast,  // frame_last
  // Result words
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [10:0] ring_slot, [15:11] block_index, [27:16] fill_level,
  // [39:28] worst_fill, [71:40] overflow_count, [103:72] silence_count,
  // [135:104] blocks_count, [167:136] frames_count
  output logic [arbf_pkg::ODATA_W-1:0]  out_tdata,
  output logic [arbf_pkg::KIND_W-1:0]   out_tuser, // [1:0] kind
  output logic                          out_tlast  // last
);
  import arbf_pkg::*;

  arbf_cmd_t  cmd;
  arbf_stat_t stat;

  // Sequencer: one word at a time, waits on the output register
  arbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Pointers, counters and the result register
  arbf_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_frame_last (in_tlast),
    .in_mode       (in_tuser),
    .in_play_blk   (in_tdata[BLK_W-1:0]),
    .cmd           (cmd),
    .stat          (stat),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tlast     (out_tlast),
    .out_kind      (out_tuser),
    .out_data      (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // Fill level never exceeds ring capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:16] <= RING_FULL))
    else $error("fill level beyond ring capacity");

  // A push yields exactly one word, so stored or dropped results are final
  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_STORED || out_tuser == KIND_DROPPED))
      |-> out_tlast)
    else $error("push result without last");

  // Dropped pairs and silence blocks carry no ring slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_DROPPED || out_tuser == KIND_SILENCE))
      |-> (out_tdata[10:0] == '0))
    else $error("non-zero slot on drop or silence");

  // No word is accepted while the sequencer still owes results
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a word while busy");
`endif

endmodule
